/* sv/cwnu_pkg.sv */
// ----------------------------------------------------------------------------
// cwnu_pkg
// Shared widths, result codes and controller types for the node update block.
// ----------------------------------------------------------------------------
`default_nettype none

package cwnu_pkg;

	localparam int MAX_LINKS_DEF = 64;

	localparam int P_W      = 24;               // pressure, Q8.16
	localparam int G_W      = 24;               // conductance, UQ8.16
	localparam int PROD_W   = 48;               // conductance * pressure
	localparam int WSUM_W   = 55;               // signed Q23.32 accumulator
	localparam int WT_W     = 31;               // unsigned Q15.16 accumulator
	localparam int DVD_W    = 56;               // rounded dividend magnitude
	localparam int QUO_W    = 25;               // quotient bits produced
	localparam int STS_W    = 2;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 32;

	localparam logic [P_W-1:0] P_MAX = 24'h7F_FFFF;
	localparam logic [P_W-1:0] P_MIN = 24'h80_0000;

	typedef enum logic [STS_W-1:0] {
		RES_OK        = 2'd0,
		RES_ZERO_COND = 2'd1,
		RES_TOO_MANY  = 2'd2
	} res_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_CHK,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic acc;
		logic div_start;
		logic load_out;
		logic clr;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last;
		logic special;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

/* sv/conductance_weighted_node_update.sv */
// ----------------------------------------------------------------------------
// conductance_weighted_node_update
// One node's relaxation update: conductance-weighted average of neighbor
// pressures, rounded to nearest with ties away from zero.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the links of one node on the slave stream, one transaction per link,
//   with tlast on the final link. tuser carries the boundary flag; own pressure
//   and the boundary flag are taken from the last link only.
//   One transaction leaves the master stream per node: the new pressure and a
//   status (ok, zero total conductance, too many links).
// Sequence:
//   A link that is not last is captured with the multiply, then accumulated;
//   no new link is taken until it is accumulated. A last link is captured,
//   accumulated and checked; when an average is formed it then goes through
//   the one-bit-per-cycle divider (25 quotient bits, then done) before the
//   output register is loaded, while a special case skips the divider.
//   The divider sets the node cost.
// Reset:
//   arst_n clears the accumulators, link count, sequencer and tvalid at once.
// Stall:
//   The output register holds the result until taken; links of the next node
//   are accepted meanwhile. A second result waits in the sequencer (s_tready
//   low) until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module conductance_weighted_node_update
	import cwnu_pkg::*;
#(
	parameter int MAX_LINKS = MAX_LINKS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// [23:0] conductance, [47:24] neighbor_pressure, [71:48] own_pressure
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// [0] is_boundary
	input  wire logic                s_tuser,
	input  wire logic                s_tlast,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// [23:0] new_pressure, [25:24] status, [31:26] zero
	output logic [M_DATA_W-1:0]      m_tdata
);

	cmd_t                    cmd;
	sts_t                    sts;
	logic signed [P_W-1:0]   new_pressure;
	logic        [STS_W-1:0] status;

	// sequencer
	cwnu_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.sts     (sts),
		.in_ready(s_tready),
		.cmd     (cmd)
	);

	// unpack the link fields straight into the datapath
	cwnu_dp #(
		.MAX_LINKS(MAX_LINKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.conductance      (s_tdata[G_W-1:0]),
		.neighbor_pressure(s_tdata[G_W+P_W-1:G_W]),
		.own_pressure     (s_tdata[G_W+2*P_W-1:G_W+P_W]),
		.is_boundary      (s_tuser),
		.last_link        (s_tlast),
		.m_ready          (m_tready),
		.m_valid          (m_tvalid),
		.new_pressure     (new_pressure),
		.status           (status)
	);

	// pack the result, zero fill to whole bytes
	assign m_tdata = {{(M_DATA_W-P_W-STS_W){1'b0}}, status, new_pressure};

endmodule

`default_nettype wire

/* sv/cwnu_div.sv */
// ----------------------------------------------------------------------------
// cwnu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cwnu_div
	import cwnu_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dvd,
	input  wire logic [WT_W-1:0]  dsr,
	output logic      [QUO_W-1:0] quo,
	output logic                  done
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [WT_W-1:0]  rem_q;
	logic [QUO_W-1:0] sh_q;
	logic [CNT_W-1:0] cnt_q;

	logic [WT_W:0]    rem2;
	logic             ge;
	logic [WT_W:0]    diff;

	assign rem2 = {rem_q, sh_q[QUO_W-1]};
	assign ge   = rem2 >= {1'b0, dsr};
	assign diff = rem2 - {1'b0, dsr};

	// quotient fits QUO_W bits, so the upper dividend bits are already below dsr
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(QUO_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dvd[DVD_W-1:QUO_W];
			sh_q  <= dvd[QUO_W-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[WT_W-1:0] : rem2[WT_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign quo  = sh_q;
	assign done = (cnt_q == '0);

endmodule

`default_nettype wire

/* sv/cwnu_dp.sv */
// ----------------------------------------------------------------------------
// cwnu_dp
// Datapath: link product, accumulators, rounding divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cwnu_dp
	import cwnu_pkg::*;
#(
	parameter int MAX_LINKS = MAX_LINKS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	output sts_t                         sts,
	input  wire logic        [G_W-1:0]   conductance,
	input  wire logic signed [P_W-1:0]   neighbor_pressure,
	input  wire logic signed [P_W-1:0]   own_pressure,
	input  wire logic                    is_boundary,
	input  wire logic                    last_link,
	input  wire logic                    m_ready,
	output logic                         m_valid,
	output logic signed      [P_W-1:0]   new_pressure,
	output logic             [STS_W-1:0] status
);

	localparam int CNT_W = $clog2(MAX_LINKS + 1);

	logic signed [PROD_W:0]   prod_full;
	logic signed [PROD_W-1:0] prod_s1;
	logic [G_W-1:0]           cond_q;
	logic [P_W-1:0]           own_q;
	logic                     boundary_q;
	logic                     last_q;

	logic [WSUM_W-1:0]        wsum_q;
	logic [WT_W-1:0]          wt_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     ovf_q;

	logic                     m_valid_q;
	logic [P_W-1:0]           press_q;
	logic [STS_W-1:0]         stat_q;

	logic                     full;
	logic                     wt_zero;
	logic                     neg;
	logic [DVD_W-1:0]         wsum_x;
	logic [DVD_W-1:0]         half_x;
	logic [DVD_W-1:0]         dvd;
	logic [QUO_W-1:0]         quo;
	logic                     div_done;
	logic [QUO_W-1:0]         quo_neg;
	logic [P_W-1:0]           avg;
	logic [P_W-1:0]           res_press;
	res_code_t                res_code;

	assign prod_full = $signed({1'b0, conductance}) * neighbor_pressure;

	// hold the link until the accumulate cycle
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			prod_s1    <= prod_full[PROD_W-1:0];
			cond_q     <= conductance;
			own_q      <= own_pressure;
			boundary_q <= is_boundary;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
		end else if (cmd.capture) begin
			last_q <= last_link;
		end
	end

	assign full = (cnt_q >= CNT_W'(MAX_LINKS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			wt_q   <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.clr) begin
			wsum_q <= '0;
			wt_q   <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.acc) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				wsum_q <= wsum_q + {{(WSUM_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
				wt_q   <= wt_q + {{(WT_W-G_W){1'b0}}, cond_q};
				cnt_q  <= cnt_q + 1'b1;
			end
		end
	end

	// |wsum| + wt/2 in one adder: for a negative sum it is wt/2 - wsum
	assign neg    = wsum_q[WSUM_W-1];
	assign wsum_x = {{(DVD_W-WSUM_W){wsum_q[WSUM_W-1]}}, wsum_q};
	assign half_x = {{(DVD_W-WT_W+1){1'b0}}, wt_q[WT_W-1:1]};
	assign dvd    = neg ? (half_x - wsum_x) : (wsum_x + half_x);

	cwnu_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.dvd   (dvd),
		.dsr   (wt_q),
		.quo   (quo),
		.done  (div_done)
	);

	assign quo_neg = -quo;

	always_comb begin
		if (neg) begin
			avg = (quo > QUO_W'(P_MIN)) ? P_MIN : quo_neg[P_W-1:0];
		end else begin
			avg = (quo > QUO_W'(P_MAX)) ? P_MAX : quo[P_W-1:0];
		end
	end

	assign wt_zero = (wt_q == '0);

	always_comb begin
		res_press = own_q;
		res_code  = RES_OK;
		if (ovf_q) begin
			res_code = RES_TOO_MANY;
		end else if (boundary_q) begin
			res_code = RES_OK;
		end else if (wt_zero) begin
			res_code = RES_ZERO_COND;
		end else begin
			res_press = avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			press_q <= res_press;
			stat_q  <= res_code;
		end
	end

	assign sts.last     = last_q;
	assign sts.special  = ovf_q | boundary_q | wt_zero;
	assign sts.div_done = div_done;
	assign sts.out_free = !m_valid_q || m_ready;

	assign m_valid      = m_valid_q;
	assign new_pressure = press_q;
	assign status       = stat_q;

endmodule

`default_nettype wire

/* sv/cwnu_ctrl.sv */
// ----------------------------------------------------------------------------
// cwnu_ctrl
// Sequencer: accept, accumulate, check, divide, hand over the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cwnu_ctrl
	import cwnu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output logic      in_ready,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = sts.last ? ST_CHK : ST_IDLE;
			end
			ST_CHK: begin
				state_d = sts.special ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
			end
			ST_CHK: begin
				cmd.div_start = !sts.special;
			end
			ST_OUT: begin
				cmd.load_out = sts.out_free;
				cmd.clr      = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/cwnu_chk.sv */
// ----------------------------------------------------------------------------
// cwnu_chk
// Port-level checks for the node update block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cwnu_chk
	import cwnu_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// each link is accumulated in the cycle after its transaction
	a_one_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("link accepted during accumulate");

	// a result is loaded only from the output state, never while taking links
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while input was open");

	// status is never the unused code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[P_W+STS_W-1:P_W] != 2'b11)
		else $error("invalid status code");

endmodule

bind conductance_weighted_node_update cwnu_chk u_chk (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire
